FILE: hw/rtl/rtb_pkg.sv
package rtb_pkg;

    // Operation codes of the func field.
    localparam logic [3:0] FUNC_ADD         = 4'd0;
    localparam logic [3:0] FUNC_REMOVE_SLOT = 4'd1;
    localparam logic [3:0] FUNC_REMOVE_TYPE = 4'd2;
    localparam logic [3:0] FUNC_REMOVE_ALL  = 4'd3;
    localparam logic [3:0] FUNC_SET_REMAIN  = 4'd4;
    localparam logic [3:0] FUNC_SET_PERIOD  = 4'd5;
    localparam logic [3:0] FUNC_SET_BOTH    = 4'd6;
    localparam logic [3:0] FUNC_QUERY       = 4'd7;
    localparam logic [3:0] FUNC_TICK        = 4'd8;

    // Status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [31:0] INFINITE_REPEATS = 32'hFFFF_FFFF;
    localparam int unsigned MAX_FIRE_REPORTS = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WALK,
        ST_FIRE,
        ST_DONE
    } t_state;

endpackage

FILE: hw/rtl/repeating_timer_bank_top.sv
// Every code, add, remove, set, query, tick and unknown codes alike, walks all
// SLOTS entries, each slot in a read state (memory read) and then a walk state
// (compare and update), then reports in a done state. A new word is taken only
// in idle, after the result; a tick adds a fire state per fired word, output
// stalls hold it; not ready while busy. Up to 16 fired words per tick.
// Reset clears the used bits and the sequencer; slot contents need no reset.
module repeating_timer_bank_top #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_func,
    input  logic [15:0] i_event_type,
    input  logic [3:0]  i_slot_index,
    input  logic [31:0] i_time_value,
    input  logic [31:0] i_repeat_count,
    input  logic        i_one_shot,
    input  logic        i_unconditioned,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_fired,
    output logic [3:0]  o_fired_slot,
    output logic [15:0] o_fired_type,
    output logic        o_found,
    output logic [31:0] o_time_left,
    output logic [31:0] o_period_out,
    output logic [31:0] o_repeats_out,
    output logic        o_last
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int KW = $clog2(rtb_pkg::MAX_FIRE_REPORTS + 1);

    // Slot storage: used and marked bits in flops, the rest in a memory.
    logic [SLOTS-1:0] r_used, n_used;
    logic [SLOTS-1:0] r_marked, n_marked;
    logic [15:0] m_type [SLOTS];
    logic [31:0] m_period [SLOTS];
    logic [31:0] m_remain [SLOTS];
    logic [31:0] m_repeats [SLOTS];
    logic        m_one_shot [SLOTS];

    rtb_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [KW-1:0] r_kcnt, n_kcnt;
    logic r_hit, n_hit, r_fnd, n_fnd;
    logic [3:0]  r_func;
    logic [15:0] r_etype;
    logic [3:0]  r_sidx;
    logic [31:0] r_tval, r_reps;
    logic        r_oneshot, r_uncond;

    // Registered read data of the current slot.
    logic [15:0] r_rd_type;
    logic [31:0] r_rd_period, r_rd_remain, r_rd_repeats;
    logic        r_rd_one_shot;

    // Walk results, kept apart from the output register until reported.
    logic [3:0]  r_acc_slot, n_acc_slot;
    logic [15:0] r_acc_type, n_acc_type;
    logic [31:0] r_acc_tleft, n_acc_tleft, r_acc_per, n_acc_per;
    logic [31:0] r_acc_rep, n_acc_rep;

    // Output register.
    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_status, n_status;
    logic        r_fired, n_fired, r_found, n_found, r_last, n_last;
    logic [3:0]  r_oslot, n_oslot;
    logic [15:0] r_otype, n_otype;
    logic [31:0] r_tleft, n_tleft, r_per, n_per, r_rep, n_rep;

    // Memory write port.
    logic        w_en, w_remain_en, w_period_en, w_repeats_en;
    logic [31:0] w_remain, w_period, w_repeats;

    logic [IW-1:0] idx;
    logic          match, used_i, marked_i, expired;
    logic [31:0]   dec_rep;

    assign idx      = r_idx[IW-1:0];
    assign used_i   = r_used[idx];
    assign marked_i = r_marked[idx];
    assign match    = used_i && (r_rd_type == r_etype);
    assign expired  = (r_rd_remain <= r_tval);
    assign dec_rep  = r_rd_repeats - 32'd1;
    assign o_ready  = (r_state == rtb_pkg::ST_IDLE);

    // Slot memory, one read and one write per cycle.
    always_ff @(posedge i_clk) begin
        r_rd_type     <= m_type[idx];
        r_rd_period   <= m_period[idx];
        r_rd_remain   <= m_remain[idx];
        r_rd_repeats  <= m_repeats[idx];
        r_rd_one_shot <= m_one_shot[idx];
        if (w_en) begin
            m_type[idx]     <= r_etype;
            m_one_shot[idx] <= r_oneshot;
        end
        if (w_remain_en) begin
            m_remain[idx] <= w_remain;
        end
        if (w_period_en) begin
            m_period[idx] <= w_period;
        end
        if (w_repeats_en) begin
            m_repeats[idx] <= w_repeats;
        end
    end

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_func    <= i_func;
            r_etype   <= i_event_type;
            r_sidx    <= i_slot_index;
            r_tval    <= i_time_value;
            r_reps    <= i_repeat_count;
            r_oneshot <= i_one_shot;
            r_uncond  <= i_unconditioned;
        end
    end

    // Control and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rtb_pkg::ST_IDLE;
            r_used   <= '0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_ovalid <= n_ovalid;
            r_idx    <= n_idx;
        end
        r_marked    <= n_marked;
        r_kcnt      <= n_kcnt;
        r_hit       <= n_hit;
        r_fnd       <= n_fnd;
        r_acc_slot  <= n_acc_slot;
        r_acc_type  <= n_acc_type;
        r_acc_tleft <= n_acc_tleft;
        r_acc_per   <= n_acc_per;
        r_acc_rep   <= n_acc_rep;
        r_status    <= n_status;
        r_fired     <= n_fired;
        r_found     <= n_found;
        r_last      <= n_last;
        r_oslot     <= n_oslot;
        r_otype     <= n_otype;
        r_tleft     <= n_tleft;
        r_per       <= n_per;
        r_rep       <= n_rep;
    end

    // Sequencer: one slot at a time, a read state then a walk state, through the shared compare/subtract.
    always_comb begin
        n_state = r_state;  n_used = r_used;  n_marked = r_marked;
        n_idx = r_idx;  n_kcnt = r_kcnt;  n_hit = r_hit;  n_fnd = r_fnd;
        n_acc_slot = r_acc_slot;  n_acc_type = r_acc_type;
        n_acc_tleft = r_acc_tleft;  n_acc_per = r_acc_per;  n_acc_rep = r_acc_rep;
        n_ovalid = r_ovalid;  n_status = r_status;  n_fired = r_fired;
        n_found = r_found;  n_last = r_last;  n_oslot = r_oslot;
        n_otype = r_otype;  n_tleft = r_tleft;  n_per = r_per;  n_rep = r_rep;
        w_en = 1'b0;  w_remain_en = 1'b0;  w_period_en = 1'b0;
        w_repeats_en = 1'b0;
        w_remain = r_tval;  w_period = r_tval;  w_repeats = r_reps;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            rtb_pkg::ST_IDLE: begin
                n_idx = '0;  n_kcnt = '0;  n_hit = 1'b0;  n_fnd = 1'b0;
                n_acc_tleft = '0;  n_acc_per = '0;  n_acc_rep = '0;
                if (i_valid) begin
                    n_state = rtb_pkg::ST_READ;
                end
            end
            rtb_pkg::ST_READ: begin
                n_state = rtb_pkg::ST_WALK;
            end
            rtb_pkg::ST_WALK: begin
                n_state = rtb_pkg::ST_READ;
                case (r_func)
                    rtb_pkg::FUNC_ADD: begin
                        if (!used_i && !r_hit) begin
                            n_hit = 1'b1;  n_used[idx] = 1'b1;
                            n_marked[idx] = 1'b0;  w_en = 1'b1;
                            w_remain_en = 1'b1;  w_period_en = 1'b1;
                            w_repeats_en = 1'b1;
                            n_acc_slot = 4'(r_idx);
                        end
                    end
                    rtb_pkg::FUNC_REMOVE_SLOT: begin
                        if (used_i && (32'(r_sidx) == 32'(r_idx))) begin
                            n_hit = 1'b1;  n_marked[idx] = 1'b1;
                        end
                    end
                    rtb_pkg::FUNC_REMOVE_ALL: begin
                        if (used_i) begin
                            n_marked[idx] = 1'b1;
                        end
                    end
                    rtb_pkg::FUNC_REMOVE_TYPE, rtb_pkg::FUNC_SET_REMAIN,
                    rtb_pkg::FUNC_SET_PERIOD, rtb_pkg::FUNC_SET_BOTH: begin
                        if (match) begin
                            n_hit = 1'b1;
                            case (r_func)
                                rtb_pkg::FUNC_REMOVE_TYPE: n_marked[idx] = 1'b1;
                                rtb_pkg::FUNC_SET_REMAIN: begin
                                    w_remain_en = 1'b1;
                                    w_remain = (r_uncond || r_tval <= r_rd_period)
                                        ? r_tval : r_rd_period;
                                end
                                rtb_pkg::FUNC_SET_PERIOD: w_period_en = 1'b1;
                                default: begin
                                    w_period_en = 1'b1;  w_remain_en = 1'b1;
                                end
                            endcase
                        end
                    end
                    rtb_pkg::FUNC_QUERY: begin
                        if (match) begin
                            if (!r_hit) begin
                                n_acc_per = r_rd_period;  n_acc_rep = r_rd_repeats;
                            end
                            n_hit = 1'b1;
                            if (!r_fnd && !marked_i) begin
                                n_fnd = 1'b1;  n_acc_tleft = r_rd_remain;
                            end
                        end
                    end
                    rtb_pkg::FUNC_TICK: begin
                        if (used_i) begin
                            if (marked_i) begin
                                n_used[idx] = 1'b0;
                            end else if (expired) begin
                                if (r_kcnt < KW'(rtb_pkg::MAX_FIRE_REPORTS)) begin
                                    n_kcnt = r_kcnt + KW'(1);
                                    n_state = rtb_pkg::ST_FIRE;
                                    n_acc_slot = 4'(r_idx);
                                    n_acc_type = r_rd_type;
                                end
                                if (r_rd_one_shot) begin
                                    n_marked[idx] = 1'b1;
                                end else begin
                                    w_remain_en = 1'b1;  w_remain = r_rd_period;
                                    if (r_rd_repeats != rtb_pkg::INFINITE_REPEATS) begin
                                        w_repeats_en = 1'b1;  w_repeats = dec_rep;
                                        if (dec_rep == '0) begin
                                            n_marked[idx] = 1'b1;
                                        end
                                    end
                                end
                            end else begin
                                w_remain_en = 1'b1;  w_remain = r_rd_remain - r_tval;
                            end
                        end
                    end
                    default: ;
                endcase
                n_idx = r_idx + CW'(1);
                if (r_idx == CW'(SLOTS - 1) && n_state == rtb_pkg::ST_READ) begin
                    n_state = rtb_pkg::ST_DONE;
                end
            end
            rtb_pkg::ST_FIRE: begin
                // Hold until the output register is free, then report.
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;  n_status = rtb_pkg::STATUS_OK;
                    n_fired = 1'b1;  n_found = 1'b0;  n_last = 1'b0;
                    n_oslot = r_acc_slot;  n_otype = r_acc_type;
                    n_tleft = '0;  n_per = '0;  n_rep = '0;
                    n_state = (r_idx == CW'(SLOTS)) ? rtb_pkg::ST_DONE
                                                     : rtb_pkg::ST_READ;
                end
            end
            rtb_pkg::ST_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;  n_fired = 1'b0;  n_last = 1'b1;
                    n_found = 1'b0;  n_otype = '0;
                    n_state = rtb_pkg::ST_IDLE;
                    n_status = rtb_pkg::STATUS_OK;
                    n_oslot = (r_func == rtb_pkg::FUNC_ADD && r_hit) ? r_acc_slot : '0;
                    case (r_func)
                        rtb_pkg::FUNC_ADD:
                            n_status = r_hit ? rtb_pkg::STATUS_OK : rtb_pkg::STATUS_FULL;
                        rtb_pkg::FUNC_REMOVE_SLOT, rtb_pkg::FUNC_REMOVE_TYPE,
                        rtb_pkg::FUNC_SET_REMAIN, rtb_pkg::FUNC_SET_PERIOD,
                        rtb_pkg::FUNC_SET_BOTH:
                            n_status = r_hit ? rtb_pkg::STATUS_OK
                                             : rtb_pkg::STATUS_NOT_FOUND;
                        rtb_pkg::FUNC_QUERY: begin
                            n_status = r_hit ? rtb_pkg::STATUS_OK
                                             : rtb_pkg::STATUS_NOT_FOUND;
                            n_found = r_fnd;
                        end
                        default: ;
                    endcase
                    if (r_func == rtb_pkg::FUNC_QUERY) begin
                        n_tleft = r_acc_tleft;  n_per = r_acc_per;  n_rep = r_acc_rep;
                    end else begin
                        n_tleft = '0;  n_per = '0;  n_rep = '0;
                    end
                end
            end
            default: n_state = rtb_pkg::ST_IDLE;
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_fired       = r_fired;
    assign o_fired_slot  = r_oslot;
    assign o_fired_type  = r_otype;
    assign o_found       = r_found;
    assign o_time_left   = r_tleft;
    assign o_period_out  = r_per;
    assign o_repeats_out = r_rep;
    assign o_last        = r_last;

    // A word is only taken in idle.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == rtb_pkg::ST_IDLE)) else $error("ready while busy");
    // A fired word never closes an operation.
    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fired) |-> !o_last) else $error("fired word marked last");
    // The walk index stays within the table.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rtb_pkg::ST_WALK) |-> (r_idx < CW'(SLOTS)))
        else $error("walk index out of range");
endmodule

FILE: sim/repeating_timer_bank_top_tb.sv
`timescale 1ns / 100ps

module repeating_timer_bank_top_tb;

    localparam int NUM_SLOTS = 16;

    // Range of func codes that the block treats as no operation.
    localparam logic [3:0] FUNC_UNUSED_FIRST = 4'd9;
    localparam logic [3:0] FUNC_UNUSED_LAST  = 4'd15;

    // One operation word together with the pacing that goes with it.
    typedef struct {
        logic [3:0]  func;
        logic [15:0] etype;
        logic [3:0]  sidx;
        logic [31:0] tval;
        logic [31:0] reps;
        logic        one_shot;
        logic        uncond;
        int          idle_pct;
        int          stall_pct;
        bit          drain;
        bit          hold_rx;
    } t_op_word;

    // One result word as the block reports it.
    typedef struct packed {
        logic [1:0]  status;
        logic        fired;
        logic [3:0]  fired_slot;
        logic [15:0] fired_type;
        logic        found;
        logic [31:0] time_left;
        logic [31:0] period_out;
        logic [31:0] repeats_out;
        logic        last;
    } t_result_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [3:0]  i_func = '0;
    logic [15:0] i_event_type = '0;
    logic [3:0]  i_slot_index = '0;
    logic [31:0] i_time_value = '0;
    logic [31:0] i_repeat_count = '0;
    logic        i_one_shot = 1'b0;
    logic        i_unconditioned = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic        o_fired;
    logic [3:0]  o_fired_slot;
    logic [15:0] o_fired_type;
    logic        o_found;
    logic [31:0] o_time_left;
    logic [31:0] o_period_out;
    logic [31:0] o_repeats_out;
    logic        o_last;

    repeating_timer_bank_top #(.SLOTS(NUM_SLOTS)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_event_type(i_event_type), .i_slot_index(i_slot_index),
        .i_time_value(i_time_value), .i_repeat_count(i_repeat_count),
        .i_one_shot(i_one_shot), .i_unconditioned(i_unconditioned),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status), .o_fired(o_fired),
        .o_fired_slot(o_fired_slot), .o_fired_type(o_fired_type), .o_found(o_found),
        .o_time_left(o_time_left), .o_period_out(o_period_out),
        .o_repeats_out(o_repeats_out), .o_last(o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_op_word     pending_ops[$];
    t_result_word expected_results[$];
    t_op_word     current_op;
    int           stall_pct = 0;
    int           hold_cycles = 0;
    logic         hold_req = 1'b0;
    bit           failed = 0;

    // Shadow copy of the timer table.
    bit          tbl_used[NUM_SLOTS];
    bit          tbl_marked[NUM_SLOTS];
    logic [15:0] tbl_type[NUM_SLOTS];
    logic [31:0] tbl_period[NUM_SLOTS];
    logic [31:0] tbl_remaining[NUM_SLOTS];
    logic [31:0] tbl_repeats[NUM_SLOTS];
    bit          tbl_one_shot[NUM_SLOTS];

    // Append one operation to the stimulus queue.
    task automatic enqueue_op(input t_op_word op);
        pending_ops = {pending_ops, op};
    endtask

    // Apply one operation to the shadow table and queue the words it yields.
    task automatic apply_timer_op(input t_op_word op);
        t_result_word r;
        int           slot;
        int           fire_count;
        bit           hit;
        r = '0;
        r.last = 1'b1;
        hit = 0;
        slot = -1;
        case (op.func)
            rtb_pkg::FUNC_ADD: begin
                for (int i = NUM_SLOTS - 1; i >= 0; i--)
                    if (!tbl_used[i]) slot = i;
                if (slot < 0) begin
                    r.status = rtb_pkg::STATUS_FULL;
                end else begin
                    tbl_used[slot] = 1;
                    tbl_marked[slot] = 0;
                    tbl_type[slot] = op.etype;
                    tbl_period[slot] = op.tval;
                    tbl_remaining[slot] = op.tval;
                    tbl_repeats[slot] = op.reps;
                    tbl_one_shot[slot] = op.one_shot;
                    r.fired_slot = slot[3:0];
                end
            end
            rtb_pkg::FUNC_REMOVE_SLOT: begin
                if (tbl_used[op.sidx]) tbl_marked[op.sidx] = 1;
                else r.status = rtb_pkg::STATUS_NOT_FOUND;
            end
            rtb_pkg::FUNC_REMOVE_ALL: begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (tbl_used[i]) tbl_marked[i] = 1;
            end
            rtb_pkg::FUNC_REMOVE_TYPE, rtb_pkg::FUNC_SET_REMAIN,
            rtb_pkg::FUNC_SET_PERIOD, rtb_pkg::FUNC_SET_BOTH: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (tbl_used[i] && tbl_type[i] == op.etype) begin
                        hit = 1;
                        case (op.func)
                            rtb_pkg::FUNC_REMOVE_TYPE: tbl_marked[i] = 1;
                            rtb_pkg::FUNC_SET_REMAIN: tbl_remaining[i] =
                                (op.uncond || op.tval <= tbl_period[i]) ? op.tval
                                                                        : tbl_period[i];
                            rtb_pkg::FUNC_SET_PERIOD: tbl_period[i] = op.tval;
                            default: begin
                                tbl_period[i] = op.tval;
                                tbl_remaining[i] = op.tval;
                            end
                        endcase
                    end
                end
                if (!hit) r.status = rtb_pkg::STATUS_NOT_FOUND;
            end
            rtb_pkg::FUNC_QUERY: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (tbl_used[i] && tbl_type[i] == op.etype) begin
                        if (!hit) begin
                            hit = 1;
                            r.period_out = tbl_period[i];
                            r.repeats_out = tbl_repeats[i];
                        end
                        if (!r.found && !tbl_marked[i]) begin
                            r.found = 1'b1;
                            r.time_left = tbl_remaining[i];
                        end
                    end
                end
                if (!hit) r.status = rtb_pkg::STATUS_NOT_FOUND;
            end
            rtb_pkg::FUNC_TICK: begin
                fire_count = 0;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!tbl_used[i]) continue;
                    if (tbl_marked[i]) begin
                        tbl_used[i] = 0;
                        continue;
                    end
                    if (tbl_remaining[i] <= op.tval) begin
                        if (fire_count < rtb_pkg::MAX_FIRE_REPORTS) begin
                            t_result_word f;
                            f = '0;
                            f.fired = 1'b1;
                            f.fired_slot = i[3:0];
                            f.fired_type = tbl_type[i];
                            expected_results = {expected_results, f};
                            fire_count++;
                        end
                        if (tbl_one_shot[i]) begin
                            tbl_marked[i] = 1;
                            continue;
                        end
                        tbl_remaining[i] = tbl_period[i];
                        if (tbl_repeats[i] != rtb_pkg::INFINITE_REPEATS) begin
                            tbl_repeats[i] = tbl_repeats[i] - 32'd1;
                            if (tbl_repeats[i] == 0) tbl_marked[i] = 1;
                        end
                    end else begin
                        tbl_remaining[i] = tbl_remaining[i] - op.tval;
                    end
                end
            end
            default: ;
        endcase
        expected_results = {expected_results, r};
    endtask

    function automatic t_op_word mk_op(logic [3:0] func, logic [15:0] etype,
                                       logic [31:0] tval, logic [31:0] reps);
        t_op_word op;
        op.func = func;
        op.etype = etype;
        op.sidx = 4'($urandom_range(15));
        op.tval = tval;
        op.reps = reps;
        op.one_shot = 1'b0;
        op.uncond = 1'b0;
        op.idle_pct = 0;
        op.stall_pct = 0;
        op.drain = 0;
        op.hold_rx = 0;
        return op;
    endfunction

    // Random operation biased toward a few shared types and short times.
    function automatic t_op_word rand_op();
        t_op_word    op;
        logic [15:0] types[4] = '{16'h0000, 16'h0001, 16'h00A5, 16'hFFFF};
        int          pick;
        pick = $urandom_range(99);
        op = mk_op(rtb_pkg::FUNC_TICK, types[$urandom_range(3)], $urandom_range(40),
                   $urandom_range(3));
        if (pick < 30) op.func = rtb_pkg::FUNC_ADD;
        else if (pick < 55) op.func = rtb_pkg::FUNC_TICK;
        else if (pick < 95) op.func = 4'($urandom_range(32'(rtb_pkg::FUNC_REMOVE_SLOT),
                                                        32'(rtb_pkg::FUNC_QUERY)));
        else op.func = 4'($urandom_range(32'(FUNC_UNUSED_FIRST), 32'(FUNC_UNUSED_LAST)));
        if ($urandom_range(9) == 0) op.etype = 16'($urandom);
        if ($urandom_range(7) == 0) op.tval = $urandom;
        case ($urandom_range(5))
            0: op.reps = rtb_pkg::INFINITE_REPEATS;
            1: op.reps = $urandom;
            default: ;
        endcase
        op.one_shot = 1'($urandom_range(1));
        op.uncond = 1'($urandom_range(1));
        return op;
    endfunction

    // Driver: offers pending words and updates the shadow table on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            hold_req <= 1'b0;
        end else begin
            if (i_valid && o_ready) apply_timer_op(current_op);
            if (!i_valid || o_ready) begin
                if (pending_ops.size() > 0
                        && !(pending_ops[0].drain && expected_results.size() > 0)
                        && $urandom_range(99) >= pending_ops[0].idle_pct) begin
                    current_op = pending_ops.pop_front();
                    i_valid <= 1'b1;
                    i_func <= current_op.func;
                    i_event_type <= current_op.etype;
                    i_slot_index <= current_op.sidx;
                    i_time_value <= current_op.tval;
                    i_repeat_count <= current_op.reps;
                    i_one_shot <= current_op.one_shot;
                    i_unconditioned <= current_op.uncond;
                    stall_pct <= current_op.stall_pct;
                    hold_req <= current_op.hold_rx;
                end else begin
                    i_valid <= 1'b0;
                    hold_req <= 1'b0;
                end
            end else begin
                hold_req <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            hold_cycles <= 0;
        end else begin
            if (hold_req) hold_cycles <= 400;
            else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
            i_ready <= (hold_cycles == 0) && !hold_req
                       && ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic bit field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name,
                     exp_v, act_v);
            return 0;
        end
        return 1;
    endfunction

    // Monitor: compares each accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_result_word e;
        bit           ok;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word, status %0h fired %0b last %0b",
                         $time, o_status, o_fired, o_last);
                failed = 1;
            end else begin
                e = expected_results.pop_front();
                ok = field_ok("status", 32'(e.status), 32'(o_status));
                ok &= field_ok("fired", 32'(e.fired), 32'(o_fired));
                ok &= field_ok("fired_slot", 32'(e.fired_slot), 32'(o_fired_slot));
                ok &= field_ok("fired_type", 32'(e.fired_type), 32'(o_fired_type));
                ok &= field_ok("found", 32'(e.found), 32'(o_found));
                ok &= field_ok("time_left", e.time_left, o_time_left);
                ok &= field_ok("period_out", e.period_out, o_period_out);
                ok &= field_ok("repeats_out", e.repeats_out, o_repeats_out);
                ok &= field_ok("last", 32'(e.last), 32'(o_last));
                if (!ok) failed = 1;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        t_op_word op;
        int       idle_tbl[4] = '{0, 53, 0, 34};
        int       stall_tbl[4] = '{0, 0, 53, 34};

        for (int i = 0; i < NUM_SLOTS; i++) tbl_used[i] = 0;

        // Directed: empty-table misses, unknown codes, wrap and clamp cases.
        enqueue_op(mk_op(rtb_pkg::FUNC_QUERY, 16'h0005, 0, 0));
        op = mk_op(rtb_pkg::FUNC_REMOVE_SLOT, 16'h0000, 0, 0);
        op.sidx = 4'd15;
        enqueue_op(op);
        enqueue_op(mk_op(rtb_pkg::FUNC_TICK, 16'h0000, 32'hFFFF_FFFF, 0));
        enqueue_op(mk_op(FUNC_UNUSED_FIRST, 16'h0000, 0, 0));
        enqueue_op(mk_op(FUNC_UNUSED_LAST, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        enqueue_op(mk_op(rtb_pkg::FUNC_REMOVE_TYPE, 16'h0007, 0, 0));
        enqueue_op(mk_op(rtb_pkg::FUNC_SET_REMAIN, 16'h0007, 5, 0));
        enqueue_op(mk_op(rtb_pkg::FUNC_ADD, 16'hFFFF, 0, 0));
        enqueue_op(mk_op(rtb_pkg::FUNC_ADD, 16'h0000, 32'hFFFF_FFFF,
                         rtb_pkg::INFINITE_REPEATS));
        enqueue_op(mk_op(rtb_pkg::FUNC_ADD, 16'h0001, 10, 2));
        op = mk_op(rtb_pkg::FUNC_ADD, 16'h0002, 5, 7);
        op.one_shot = 1'b1;
        enqueue_op(op);
        enqueue_op(mk_op(rtb_pkg::FUNC_SET_REMAIN, 16'h0001, 100, 0));
        enqueue_op(mk_op(rtb_pkg::FUNC_QUERY, 16'h0001, 0, 0));
        op = mk_op(rtb_pkg::FUNC_SET_REMAIN, 16'h0001, 3, 0);
        op.uncond = 1'b1;
        enqueue_op(op);
        enqueue_op(mk_op(rtb_pkg::FUNC_SET_PERIOD, 16'h0001, 20, 0));
        enqueue_op(mk_op(rtb_pkg::FUNC_SET_BOTH, 16'h0000, 32'hFFFF_FFFE, 0));
        enqueue_op(mk_op(rtb_pkg::FUNC_TICK, 16'h0000, 5, 0));
        enqueue_op(mk_op(rtb_pkg::FUNC_QUERY, 16'hFFFF, 0, 0));
        op = mk_op(rtb_pkg::FUNC_REMOVE_SLOT, 16'h0000, 0, 0);
        op.sidx = 4'd0;
        enqueue_op(op);
        enqueue_op(mk_op(rtb_pkg::FUNC_QUERY, 16'hFFFF, 0, 0));
        enqueue_op(mk_op(rtb_pkg::FUNC_TICK, 16'h0000, 32'hFFFF_FFFF, 0));
        enqueue_op(mk_op(rtb_pkg::FUNC_REMOVE_ALL, 16'h0000, 0, 0));
        enqueue_op(mk_op(rtb_pkg::FUNC_TICK, 16'h0000, 0, 0));

        // Random phases with different pacing; each opens with a table fill.
        for (int p = 0; p < 4; p++) begin
            for (int n = 0; n < 40; n++) begin
                op = rand_op();
                if (n < 17) begin
                    op.func = rtb_pkg::FUNC_ADD;
                    op.tval = $urandom_range(30);
                end
                op.idle_pct = idle_tbl[p];
                op.stall_pct = stall_tbl[p];
                op.hold_rx = (n == 20);
                op.drain = (n == 30);
                if (n == 21) op.func = rtb_pkg::FUNC_TICK;
                if (n == 21) op.tval = 32'hFFFF_FFFF;
                enqueue_op(op);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_ops.size() == 0);
        @(posedge i_clk);
        while (i_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (!failed) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
